// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// CDRC_ASSERT holds a boolean on every clock edge outside reset.
// CDRC_ASSERT_IMP checks an implication (antecedent |-> consequent).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CDRC_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define CDRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CDRC_ASSERT(label, clk, rst_n, expr, msg)
`define CDRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/cdrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdrc_pkg;

    localparam int unsigned NUM_ROWS = 8;
    localparam int unsigned ROW_W    = $clog2(NUM_ROWS);

    // Drawing modes
    typedef enum logic {
        MODE_TIME = 1'b0,
        MODE_DATE = 1'b1
    } mode_t;

    // One request item
    typedef struct packed {
        logic       action;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       colon_on;
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] weekday;
    } request_t;

    // One row result item
    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [7:0]       panel0_bits;
        logic [7:0]       panel1_bits;
        logic [7:0]       panel2_bits;
        logic [7:0]       panel3_bits;
        logic             last_row;
    } row_t;

    // Decoded digits held for the whole frame.
    // Time: d0..d5 = hour tens/units, minute tens/units, second tens/units.
    // Date: d0..d3 = month tens/units, day tens/units, d4 = shown weekday.
    typedef struct packed {
        mode_t      mode;
        logic       colon;
        logic [3:0] d0;
        logic [3:0] d1;
        logic [3:0] d2;
        logic [3:0] d3;
        logic [3:0] d4;
        logic [3:0] d5;
    } digits_t;

    // 5x8 font, one 5-bit row per entry
    localparam logic [0:9][0:7][4:0] BIG_FONT = '{
        '{5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e},
        '{5'h04, 5'h06, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
        '{5'h0e, 5'h11, 5'h10, 5'h10, 5'h08, 5'h04, 5'h02, 5'h1f},
        '{5'h0e, 5'h11, 5'h10, 5'h0c, 5'h10, 5'h10, 5'h11, 5'h0e},
        '{5'h10, 5'h18, 5'h14, 5'h12, 5'h11, 5'h1f, 5'h10, 5'h10},
        '{5'h1f, 5'h01, 5'h01, 5'h0f, 5'h10, 5'h10, 5'h11, 5'h0e},
        '{5'h0e, 5'h11, 5'h01, 5'h0f, 5'h11, 5'h11, 5'h11, 5'h0e},
        '{5'h1f, 5'h10, 5'h10, 5'h08, 5'h04, 5'h02, 5'h02, 5'h02},
        '{5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h11, 5'h0e},
        '{5'h0e, 5'h11, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h11, 5'h0e}
    };

    // 3x5 font, bottom-aligned in the 8 rows
    localparam logic [0:9][0:7][2:0] SMALL_FONT = '{
        '{3'h0, 3'h0, 3'h0, 3'h7, 3'h5, 3'h5, 3'h5, 3'h7},
        '{3'h0, 3'h0, 3'h0, 3'h2, 3'h2, 3'h2, 3'h2, 3'h2},
        '{3'h0, 3'h0, 3'h0, 3'h7, 3'h4, 3'h7, 3'h1, 3'h7},
        '{3'h0, 3'h0, 3'h0, 3'h7, 3'h4, 3'h7, 3'h4, 3'h7},
        '{3'h0, 3'h0, 3'h0, 3'h5, 3'h5, 3'h7, 3'h4, 3'h4},
        '{3'h0, 3'h0, 3'h0, 3'h7, 3'h1, 3'h7, 3'h4, 3'h7},
        '{3'h0, 3'h0, 3'h0, 3'h7, 3'h1, 3'h7, 3'h5, 3'h7},
        '{3'h0, 3'h0, 3'h0, 3'h7, 3'h4, 3'h4, 3'h4, 3'h4},
        '{3'h0, 3'h0, 3'h0, 3'h7, 3'h5, 3'h7, 3'h5, 3'h7},
        '{3'h0, 3'h0, 3'h0, 3'h7, 3'h5, 3'h7, 3'h4, 3'h7}
    };

    // Colon (after the shift into panel 1) and dash glyph rows
    localparam logic [0:7] COLON_ROWS = 8'b0110_0110;
    localparam logic [0:7] DASH_ROWS  = 8'b0001_0000;

    function automatic logic [4:0] big_row(input logic [3:0] digit,
                                           input logic [ROW_W-1:0] row);
        logic [4:0] bits;
        bits = 5'h00;
        if (digit <= 4'd9)
        begin
            bits = BIG_FONT[digit][row];
        end
        return bits;
    endfunction

    function automatic logic [2:0] small_row(input logic [3:0] digit,
                                             input logic [ROW_W-1:0] row);
        logic [2:0] bits;
        bits = 3'h0;
        if (digit <= 4'd9)
        begin
            bits = SMALL_FONT[digit][row];
        end
        return bits;
    endfunction

    // Tens and units of a value 0..59: {tens, units}
    function automatic logic [7:0] split_tens(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] base;
        if (v >= 6'd50)      tens = 4'd5;
        else if (v >= 6'd40) tens = 4'd4;
        else if (v >= 6'd30) tens = 4'd3;
        else if (v >= 6'd20) tens = 4'd2;
        else if (v >= 6'd10) tens = 4'd1;
        else                 tens = 4'd0;
        base = 6'(tens) * 6'd10;
        return {tens, 4'(v - base)};
    endfunction

endpackage

`default_nettype wire

// ===== src/cdrc_digit_split.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Clamps the request fields and splits them into the digits to draw
module cdrc_digit_split (
    input  wire cdrc_pkg::request_t request,
    output cdrc_pkg::digits_t       digits
);

    logic [5:0] hour_c;
    logic [5:0] minute_c;
    logic [5:0] second_c;
    logic [5:0] month_c;
    logic [5:0] day_c;
    logic [2:0] wd_c;
    logic [2:0] wd_shown;
    logic [7:0] hour_s;
    logic [7:0] minute_s;
    logic [7:0] second_s;
    logic [7:0] month_s;
    logic [7:0] day_s;

    // Clamp to the legal ranges
    always_comb
    begin
        hour_c   = (request.hour > 5'd23) ? 6'd23 : {1'b0, request.hour};
        minute_c = (request.minute > 6'd59) ? 6'd59 : request.minute;
        second_c = (request.second > 6'd59) ? 6'd59 : request.second;
        if (request.month == 4'd0)
        begin
            month_c = 6'd1;
        end
        else if (request.month > 4'd12)
        begin
            month_c = 6'd12;
        end
        else
        begin
            month_c = {2'b00, request.month};
        end
        day_c    = (request.day == 5'd0) ? 6'd1 : {1'b0, request.day};
        wd_c     = (request.weekday == 3'd0) ? 3'd1 : request.weekday;
        // weekday 1 shows as 7, others one less
        wd_shown = (wd_c == 3'd1) ? 3'd7 : wd_c - 3'd1;
    end

    // Tens / units split
    always_comb
    begin
        hour_s   = cdrc_pkg::split_tens(hour_c);
        minute_s = cdrc_pkg::split_tens(minute_c);
        second_s = cdrc_pkg::split_tens(second_c);
        month_s  = cdrc_pkg::split_tens(month_c);
        day_s    = cdrc_pkg::split_tens(day_c);
    end

    // Select digits for the mode
    always_comb
    begin
        digits.mode  = cdrc_pkg::mode_t'(request.action);
        digits.colon = request.colon_on;
        unique case (digits.mode)
            cdrc_pkg::MODE_TIME:
            begin
                digits.d0 = hour_s[7:4];
                digits.d1 = hour_s[3:0];
                digits.d2 = minute_s[7:4];
                digits.d3 = minute_s[3:0];
                digits.d4 = second_s[7:4];
                digits.d5 = second_s[3:0];
            end
            cdrc_pkg::MODE_DATE:
            begin
                digits.d0 = month_s[7:4];
                digits.d1 = month_s[3:0];
                digits.d2 = day_s[7:4];
                digits.d3 = day_s[3:0];
                digits.d4 = {1'b0, wd_shown};
                digits.d5 = 4'd0;
            end
            default:
            begin
                digits.d0 = 4'd0;
                digits.d1 = 4'd0;
                digits.d2 = 4'd0;
                digits.d3 = 4'd0;
                digits.d4 = 4'd0;
                digits.d5 = 4'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/cdrc_row_compose.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Builds the four device bytes of one matrix row from font rows
module cdrc_row_compose (
    input  wire cdrc_pkg::digits_t                 digits,
    input  wire logic [cdrc_pkg::ROW_W-1:0]        row_sel,
    output cdrc_pkg::row_t                         row
);

    logic [12:0] g0;
    logic [12:0] g1;
    logic [12:0] g2;
    logic [12:0] g3;
    logic [12:0] s4;
    logic [12:0] s5;
    logic [12:0] colon_bits;
    logic [12:0] dash_bits;
    logic [12:0] p0;
    logic [12:0] p1;
    logic [12:0] p2;
    logic [12:0] p3;

    // Font lookups, widened for shifting
    always_comb
    begin
        g0 = {8'd0, cdrc_pkg::big_row(digits.d0, row_sel)};
        g1 = {8'd0, cdrc_pkg::big_row(digits.d1, row_sel)};
        g2 = {8'd0, cdrc_pkg::big_row(digits.d2, row_sel)};
        g3 = {8'd0, cdrc_pkg::big_row(digits.d3, row_sel)};
        s4 = {10'd0, cdrc_pkg::small_row(digits.d4, row_sel)};
        s5 = {10'd0, cdrc_pkg::small_row(digits.d5, row_sel)};
        colon_bits = (digits.colon && cdrc_pkg::COLON_ROWS[row_sel]) ? 13'h008 : 13'h000;
        dash_bits  = cdrc_pkg::DASH_ROWS[row_sel] ? 13'h0e0 : 13'h000;
    end

    // Glyph placement across the four devices
    always_comb
    begin
        unique case (digits.mode)
            cdrc_pkg::MODE_TIME:
            begin
                p0 = g0 | (g1 << 5);
                p1 = (g1 >> 3) | colon_bits | (g2 << 5);
                p2 = (g2 >> 3) | (g3 << 2);
                p3 = (s4 << 1) | (s5 << 5);
            end
            cdrc_pkg::MODE_DATE:
            begin
                p0 = (g0 << 2) | (g1 << 7);
                p1 = (g1 >> 1) | dash_bits;
                p2 = (g2 << 1) | (g3 << 6);
                p3 = (g3 >> 2) | (s4 << 5);
            end
            default:
            begin
                p0 = 13'd0;
                p1 = 13'd0;
                p2 = 13'd0;
                p3 = 13'd0;
            end
        endcase
    end

    always_comb
    begin
        row.row_index   = row_sel;
        row.panel0_bits = p0[7:0];
        row.panel1_bits = p1[7:0];
        row.panel2_bits = p2[7:0];
        row.panel3_bits = p3[7:0];
        row.last_row    = (row_sel == cdrc_pkg::ROW_W'(cdrc_pkg::NUM_ROWS - 1));
    end

endmodule

`default_nettype wire

// ===== src/clock_digit_row_compositor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                       Handshake
// request   start, busy, request        taken when start && !busy
// row       row_valid, row              one item per cycle, no back-pressure
//
// Each request gives eight row items, rows 0..7, on consecutive cycles.
// Row 0 is composed from the digit and row counter registers loaded when the
// request is taken, and reaches the ports through the row and valid registers.
// The row counter paces each frame; busy drops on the cycle that composes
// row 7, so the next frame follows with no gap.
// Reset clears the row counter and the active and valid flags; nothing else is reset.
// The receiver cannot stall, so rows are never held.

`include "assert_macros.svh"

module clock_digit_row_compositor (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire cdrc_pkg::request_t request,
    output logic                    row_valid,
    output cdrc_pkg::row_t          row
);

    localparam logic [cdrc_pkg::ROW_W-1:0] LAST_ROW =
        cdrc_pkg::ROW_W'(cdrc_pkg::NUM_ROWS - 1);

    cdrc_pkg::digits_t              digits_next;
    cdrc_pkg::digits_t              digits_reg;
    logic [cdrc_pkg::ROW_W-1:0]     row_cnt_reg;
    logic [cdrc_pkg::ROW_W-1:0]     row_cnt_next;
    logic                           active_reg;
    logic                           active_next;
    logic                           accept;
    cdrc_pkg::row_t                 row_next;
    cdrc_pkg::row_t                 row_reg;
    logic                           valid_reg;

    // Clamp and split on the way in
    cdrc_digit_split u_split (
        .request (request),
        .digits  (digits_next)
    );

    // Row bytes for the current row
    cdrc_row_compose u_compose (
        .digits  (digits_reg),
        .row_sel (row_cnt_reg),
        .row     (row_next)
    );

    assign busy   = active_reg && (row_cnt_reg != LAST_ROW);
    assign accept = start && !busy;

    // Row sequencing
    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        active_next  = active_reg;
        if (accept)
        begin
            row_cnt_next = '0;
            active_next  = 1'b1;
        end
        else if (active_reg)
        begin
            if (row_cnt_reg == LAST_ROW)
            begin
                active_next = 1'b0;
            end
            else
            begin
                row_cnt_next = row_cnt_reg + 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            active_reg  <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            active_reg  <= active_next;
            valid_reg   <= active_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            digits_reg <= digits_next;
        end
        if (active_reg)
        begin
            row_reg <= row_next;
        end
    end

    assign row_valid = valid_reg;
    assign row       = row_reg;

    // Checks
    `CDRC_ASSERT_IMP(a_first_row, clk, rst_n, accept, ##2 (row_valid && row.row_index == '0), "row 0 must follow a taken request")
    `CDRC_ASSERT_IMP(a_rows_contiguous, clk, rst_n, row_valid && !row.last_row, ##1 row_valid, "rows of a frame must be contiguous")
    `CDRC_ASSERT_IMP(a_busy_means_rows, clk, rst_n, busy, ##1 row_valid, "busy without a row following")
    `CDRC_ASSERT(a_last_flag, clk, rst_n, !row_valid || (row.last_row == (row.row_index == LAST_ROW)), "last_row does not match row 7")

endmodule

`default_nettype wire
